// ===== rtl/page_frame_pool_manager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page frame pool manager
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_POOL_MANAGER_CORE_ASSERT_SVH
`define PAGE_FRAME_POOL_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define PFPM_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PFPM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpm_pkg
// Types, codes and constants shared by the page frame pool manager modules.
// ----------------------------------------------------------------------------
package pfpm_pkg;

   // Default build size
   localparam int DEF_POOL_FRAMES = 64;
   localparam int DEF_PIN_BITS    = 8;

   // Fixed field widths of the ports
   localparam int OP_W          = 3;
   localparam int PAGE_W        = 32;
   localparam int CFG_W         = 7;
   localparam int FRAME_INDEX_W = 6;
   localparam int WB_W          = 7;
   localparam int COUNT_W       = 32;

   // Frame count after reset
   localparam logic [CFG_W-1:0] FRAMES_RESET = 7'd64;
   // Saturation point of the written-back field
   localparam logic [WB_W-1:0]  WB_MAX       = 7'd127;

   typedef enum logic [OP_W-1:0] {
      OP_GET         = 3'd0,
      OP_PIN         = 3'd1,
      OP_UNPIN       = 3'd2,
      OP_FLUSH_PAGE  = 3'd3,
      OP_FLUSH_ALL   = 3'd4,
      OP_RESET_STATS = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      STAT_HIT        = 3'd0,
      STAT_MISS       = 3'd1,
      STAT_NO_VICTIM  = 3'd2,
      STAT_ABSENT     = 3'd3,
      STAT_NOT_PINNED = 3'd4,
      STAT_PIN_FULL   = 3'd5,
      STAT_DONE       = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_VICTIM,
      S_FLUSH_ALL,
      S_FINISH
   } state_type;

   // One response transaction
   typedef struct packed {
      status_type                 status;
      logic [FRAME_INDEX_W-1:0]   frame_index;
      logic [WB_W-1:0]            written_back;
      logic [COUNT_W-1:0]         hit_count;
      logic [COUNT_W-1:0]         miss_count;
      logic [COUNT_W-1:0]         flush_count;
   } rsp_type;

endpackage

// ===== rtl/page_frame_pool_manager_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_pool_manager_core
// Page frame pool with rotating-hand replacement: lookup, load, pin, unpin,
// flush and statistics over a frame table held in a synchronous memory.
//
//   Port group   Direction   Handshake               Contents
//   req_*        in          req_valid / req_stall   operation, page, dirty mark
//   rsp_*        out         rsp_valid / rsp_stall   status, frame, counters
//   csr_*        in          csr_write_enable        frames in use
//
// One transaction at a time. The table is scanned one entry per cycle through
// its single read port; reset statistics and unused codes read no entry, lookup
// and flush all scan up to frames_in_use entries, and a get miss scans the table
// twice, once to look up the page and once to search for a victim.
// After reset a clearing pass over all POOL_FRAMES entries runs with req_stall high.
// A finished response waits in the output register while the next request is
// taken; a stalled response holds the sequencer only when a second one is done.
// ----------------------------------------------------------------------------
module page_frame_pool_manager_core
   import pfpm_pkg::*;
#(
   parameter int POOL_FRAMES = DEF_POOL_FRAMES,
   parameter int PIN_BITS    = DEF_PIN_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration
   input  logic                     csr_write_enable,
   input  logic [CFG_W-1:0]         csr_write_data,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [PAGE_W-1:0]        req_page_number,
   input  logic                     req_mark_dirty,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic [WB_W-1:0]          rsp_written_back,
   output logic [COUNT_W-1:0]       rsp_hit_count,
   output logic [COUNT_W-1:0]       rsp_miss_count,
   output logic [COUNT_W-1:0]       rsp_flush_count
);

   localparam int IDX_W = $clog2(POOL_FRAMES);

   logic [CFG_W-1:0]    frames_ff, frames_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   logic                out_free;
   logic                rsp_load;
   rsp_type             rsp_data;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [PAGE_W-1:0]   rd_page;
   logic                rd_valid;
   logic                rd_dirty;
   logic [PIN_BITS-1:0] rd_pins;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [PAGE_W-1:0]   wr_page;
   logic                wr_valid;
   logic                wr_dirty;
   logic [PIN_BITS-1:0] wr_pins;

   // Frame count register
   assign frames_in = csr_write_enable ? csr_write_data : frames_ff;

   // Output register: load on a finished transaction, drop when taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= FRAMES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_frame_index  = rsp_ff.frame_index;
   assign rsp_written_back = rsp_ff.written_back;
   assign rsp_hit_count    = rsp_ff.hit_count;
   assign rsp_miss_count   = rsp_ff.miss_count;
   assign rsp_flush_count  = rsp_ff.flush_count;

   // Sequencer
   pfpm_scan_ctrl #(
      .POOL_FRAMES (POOL_FRAMES),
      .PIN_BITS    (PIN_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_page_number (req_page_number),
      .req_mark_dirty  (req_mark_dirty),
      .frames_in_use   (frames_ff),
      .out_free        (out_free),
      .rsp_load        (rsp_load),
      .rsp_data        (rsp_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_page         (rd_page),
      .rd_valid        (rd_valid),
      .rd_dirty        (rd_dirty),
      .rd_pins         (rd_pins),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_page         (wr_page),
      .wr_valid        (wr_valid),
      .wr_dirty        (wr_dirty),
      .wr_pins         (wr_pins)
   );

   // Frame table
   pfpm_frame_mem #(
      .POOL_FRAMES (POOL_FRAMES),
      .PIN_BITS    (PIN_BITS)
   ) u_mem (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_page  (rd_page),
      .rd_valid (rd_valid),
      .rd_dirty (rd_dirty),
      .rd_pins  (rd_pins),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_page  (wr_page),
      .wr_valid (wr_valid),
      .wr_dirty (wr_dirty),
      .wr_pins  (wr_pins)
   );

endmodule

// ===== rtl/pfpm_frame_mem.sv =====
// ----------------------------------------------------------------------------
// pfpm_frame_mem
// Frame table: one write port, one read port, registered read data.
// Each entry holds page number, valid mark, dirty mark and pin count.
// ----------------------------------------------------------------------------
module pfpm_frame_mem
   import pfpm_pkg::*;
#(
   parameter int POOL_FRAMES = DEF_POOL_FRAMES,
   parameter int PIN_BITS    = DEF_PIN_BITS,
   localparam int IDX_W      = $clog2(POOL_FRAMES)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output logic [PAGE_W-1:0]   rd_page,
   output logic                rd_valid,
   output logic                rd_dirty,
   output logic [PIN_BITS-1:0] rd_pins,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [PAGE_W-1:0]   wr_page,
   input  logic                wr_valid,
   input  logic                wr_dirty,
   input  logic [PIN_BITS-1:0] wr_pins
);

   localparam int ENTRY_W = PAGE_W + 2 + PIN_BITS;

   logic [ENTRY_W-1:0] frame_mem_ff [POOL_FRAMES];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write and read the table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= {wr_page, wr_valid, wr_dirty, wr_pins};
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
      end
   end

   // Split the read entry
   assign rd_page  = rd_data_ff[ENTRY_W-1 -: PAGE_W];
   assign rd_valid = rd_data_ff[PIN_BITS+1];
   assign rd_dirty = rd_data_ff[PIN_BITS];
   assign rd_pins  = rd_data_ff[PIN_BITS-1:0];

endmodule

// ===== rtl/pfpm_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfpm_scan_ctrl
// Sequencer that scans the frame table one entry per cycle for lookup,
// victim search and flush all, and writes back the modified entry.
// ----------------------------------------------------------------------------
`include "page_frame_pool_manager_core_assert.svh"

module pfpm_scan_ctrl
   import pfpm_pkg::*;
#(
   parameter int POOL_FRAMES = DEF_POOL_FRAMES,
   parameter int PIN_BITS    = DEF_PIN_BITS,
   localparam int IDX_W      = $clog2(POOL_FRAMES)
) (
   input  logic                clock,
   input  logic                reset,
   // Request side
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic                req_mark_dirty,
   // Frame count register
   input  logic [CFG_W-1:0]    frames_in_use,
   // Response side
   input  logic                out_free,
   output logic                rsp_load,
   output rsp_type             rsp_data,
   // Frame table
   output logic                rd_en,
   output logic [IDX_W-1:0]    rd_addr,
   input  logic [PAGE_W-1:0]   rd_page,
   input  logic                rd_valid,
   input  logic                rd_dirty,
   input  logic [PIN_BITS-1:0] rd_pins,
   output logic                wr_en,
   output logic [IDX_W-1:0]    wr_addr,
   output logic [PAGE_W-1:0]   wr_page,
   output logic                wr_valid,
   output logic                wr_dirty,
   output logic [PIN_BITS-1:0] wr_pins
);

   localparam int CNT_W = $clog2(POOL_FRAMES + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(POOL_FRAMES - 1);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;
   op_type                op_ff, op_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic                  mark_ff, mark_in;
   logic [CNT_W-1:0]      iss_cnt_ff, iss_cnt_in;
   logic [IDX_W-1:0]      iss_addr_ff, iss_addr_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                  chk_last_ff, chk_last_in;
   logic [IDX_W-1:0]      hand_ff, hand_in;
   logic [COUNT_W-1:0]    hits_ff, hits_in;
   logic [COUNT_W-1:0]    misses_ff, misses_in;
   logic [COUNT_W-1:0]    flushes_ff, flushes_in;
   status_type            res_status_ff, res_status_in;
   logic [IDX_W-1:0]      res_frame_ff, res_frame_in;
   logic [WB_W-1:0]       res_wb_ff, res_wb_in;

   logic [CMP_W-1:0]      frames_ext;
   logic [CNT_W-1:0]      n_act;
   logic [CNT_W-1:0]      iss_cnt_nx;
   logic [CNT_W-1:0]      iss_addr_nx;
   logic [CNT_W-1:0]      chk_idx_ext;
   logic [CNT_W-1:0]      chk_idx_nx;
   logic [CNT_W-1:0]      hand_ext;
   logic [IDX_W-1:0]      hand_eff;
   logic                  scanning;
   logic                  chk_hit;
   logic                  vict_take;
   logic [IDX_W+FRAME_INDEX_W-1:0] frame_wide;

   // Clamp the frame count to 1..POOL_FRAMES
   assign frames_ext = CMP_W'(frames_in_use);
   always_comb begin
      if (frames_in_use == '0) begin
         n_act = CNT_W'(1);
      end else if (frames_ext > CMP_W'(POOL_FRAMES)) begin
         n_act = CNT_W'(POOL_FRAMES);
      end else begin
         n_act = frames_ext[CNT_W-1:0];
      end
   end

   // Scan helpers
   assign iss_cnt_nx  = iss_cnt_ff + CNT_W'(1);
   assign iss_addr_nx = CNT_W'(iss_addr_ff) + CNT_W'(1);
   assign chk_idx_ext = CNT_W'(chk_idx_ff);
   assign chk_idx_nx  = chk_idx_ext + CNT_W'(1);
   assign hand_ext    = CNT_W'(hand_ff);
   assign hand_eff    = (hand_ext >= n_act) ? '0 : hand_ff;
   assign scanning    = (state_ff == S_LOOKUP) || (state_ff == S_VICTIM) ||
                        (state_ff == S_FLUSH_ALL);
   assign chk_hit     = chk_vld_ff && rd_valid && (rd_page == page_ff);
   assign vict_take   = chk_vld_ff && (rd_pins == '0) && !rd_dirty;

   assign rd_addr     = iss_addr_ff;
   assign req_stall   = (state_ff != S_IDLE);

   // Follow each issued read into the check stage
   assign chk_vld_in  = rd_en;
   assign chk_idx_in  = iss_addr_ff;
   assign chk_last_in = (iss_cnt_nx == n_act);

   // Next state, table writes and result
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      mark_in       = mark_ff;
      iss_cnt_in    = iss_cnt_ff;
      iss_addr_in   = iss_addr_ff;
      hand_in       = hand_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      flushes_in    = flushes_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_wb_in     = res_wb_ff;
      rd_en         = 1'b0;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_page       = rd_page;
      wr_valid      = rd_valid;
      wr_dirty      = rd_dirty;
      wr_pins       = rd_pins;

      // Issue one read per cycle, wrapping at the frame count
      if (scanning && (iss_cnt_ff < n_act)) begin
         rd_en       = 1'b1;
         iss_cnt_in  = iss_cnt_nx;
         iss_addr_in = (iss_addr_nx == n_act) ? '0 : iss_addr_nx[IDX_W-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_addr_ff;
            wr_page  = '0;
            wr_valid = 1'b0;
            wr_dirty = 1'b0;
            wr_pins  = '0;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + IDX_W'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in         = op_type'(req_operation);
               page_in       = req_page_number;
               mark_in       = req_mark_dirty;
               hand_in       = hand_eff;
               iss_cnt_in    = '0;
               iss_addr_in   = '0;
               res_status_in = STAT_DONE;
               res_frame_in  = '0;
               res_wb_in     = '0;
               unique case (op_type'(req_operation))
                  OP_GET, OP_PIN, OP_UNPIN, OP_FLUSH_PAGE: begin
                     state_in = S_LOOKUP;
                  end
                  OP_FLUSH_ALL: begin
                     state_in = S_FLUSH_ALL;
                  end
                  OP_RESET_STATS: begin
                     hits_in    = '0;
                     misses_in  = '0;
                     flushes_in = '0;
                     state_in   = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_LOOKUP: begin
            if (chk_hit) begin
               // Lowest valid frame holding the page
               res_frame_in = chk_idx_ff;
               state_in     = S_FINISH;
               unique case (op_ff)
                  OP_GET: begin
                     hits_in       = hits_ff + COUNT_W'(1);
                     res_status_in = STAT_HIT;
                  end
                  OP_PIN: begin
                     if (rd_pins == PIN_MAX) begin
                        res_status_in = STAT_PIN_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_pins = rd_pins + PIN_BITS'(1);
                     end
                  end
                  OP_UNPIN: begin
                     if (rd_pins == '0) begin
                        res_status_in = STAT_NOT_PINNED;
                     end else begin
                        wr_en    = 1'b1;
                        wr_pins  = rd_pins - PIN_BITS'(1);
                        wr_dirty = rd_dirty | mark_ff;
                     end
                  end
                  OP_FLUSH_PAGE: begin
                     if (rd_dirty) begin
                        wr_en      = 1'b1;
                        wr_dirty   = 1'b0;
                        flushes_in = flushes_ff + COUNT_W'(1);
                        res_wb_in  = WB_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (chk_vld_ff && chk_last_ff) begin
               if (op_ff == OP_GET) begin
                  // Miss: search for a victim starting at the hand
                  misses_in     = misses_ff + COUNT_W'(1);
                  res_status_in = STAT_NO_VICTIM;
                  iss_cnt_in    = '0;
                  iss_addr_in   = hand_ff;
                  state_in      = S_VICTIM;
               end else begin
                  res_status_in = STAT_ABSENT;
                  state_in      = S_FINISH;
               end
            end
         end

         S_VICTIM: begin
            if (vict_take) begin
               // Load the page into the first clean unpinned frame
               wr_en         = 1'b1;
               wr_page       = page_ff;
               wr_valid      = 1'b1;
               wr_dirty      = 1'b0;
               hand_in       = (chk_idx_nx == n_act) ? '0 : chk_idx_nx[IDX_W-1:0];
               res_status_in = STAT_MISS;
               res_frame_in  = chk_idx_ff;
               state_in      = S_FINISH;
            end else if (chk_vld_ff && chk_last_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FLUSH_ALL: begin
            if (chk_vld_ff && rd_dirty) begin
               wr_en      = 1'b1;
               wr_dirty   = 1'b0;
               flushes_in = flushes_ff + COUNT_W'(1);
               if (res_wb_ff != WB_MAX) begin
                  res_wb_in = res_wb_ff + WB_W'(1);
               end
            end
            if (chk_vld_ff && chk_last_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         iss_cnt_ff  <= '0;
         chk_vld_ff  <= 1'b0;
         hand_ff     <= '0;
         hits_ff     <= '0;
         misses_ff   <= '0;
         flushes_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         iss_cnt_ff  <= iss_cnt_in;
         chk_vld_ff  <= chk_vld_in;
         hand_ff     <= hand_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
         flushes_ff  <= flushes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      page_ff       <= page_in;
      mark_ff       <= mark_in;
      iss_addr_ff   <= iss_addr_in;
      chk_idx_ff    <= chk_idx_in;
      chk_last_ff   <= chk_last_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_wb_ff     <= res_wb_in;
   end

   // Drive the result
   assign frame_wide = {{FRAME_INDEX_W{1'b0}}, res_frame_ff};
   always_comb begin
      rsp_data.status       = res_status_ff;
      rsp_data.frame_index  = frame_wide[FRAME_INDEX_W-1:0];
      rsp_data.written_back = res_wb_ff;
      rsp_data.hit_count    = hits_ff;
      rsp_data.miss_count   = misses_ff;
      rsp_data.flush_count  = flushes_ff;
   end

   // Scan writes only touch the entry currently being checked
   `PFPM_ASSERT_IMPL(a_wr_checked_entry, clock, reset, wr_en && (state_ff != S_CLEAR), chk_vld_ff && (wr_addr == chk_idx_ff), "table write outside the checked entry")
   // Checked entries stay within the frames in use
   `PFPM_ASSERT_IMPL(a_chk_in_range, clock, reset, chk_vld_ff, chk_idx_ext < n_act, "checked frame beyond frame count")
   // After a victim load the hand points at a frame in use
   `PFPM_ASSERT_NEXT(a_hand_in_range, clock, reset, (state_ff == S_VICTIM) && vict_take, hand_ext < n_act, "victim hand beyond frame count")

endmodule
